>>> rtl/dqu_pkg.sv
// Shared constants, request codes and controller/datapath interface types for the deque unit.
package dqu_pkg;

    // Queue geometry
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Field widths
    localparam int OP_W    = 3;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 2;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Largest dump report, one result per position value
    localparam int MAX_OUT = 2 ** POS_W;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP       = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic exec;      // access the store, update pointers, stage the result
        logic load;      // move the staged result into the output register
        logic advance;   // step to the next dump entry
    } dqu_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_valid;  // latched opcode gives a result
        logic out_free;  // output register can take a result this cycle
        logic more;      // staged result is a dump entry that is not the last
    } dqu_sts_t;

    // Ring slot of the entry at a given offset from the front
    function automatic logic [ADDR_W-1:0] ring_slot(
        input logic [ADDR_W-1:0] front,
        input logic [CMP_W-1:0]  offset
    );
        logic [CMP_W:0] sum;
        sum = (CMP_W + 1)'(front) + (CMP_W + 1)'(offset);
        if (sum >= (CMP_W + 1)'(DEPTH))
        begin
            sum = sum - (CMP_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

>>> rtl/dqu_ctrl.sv
// Sequencing state machine for the deque unit.
module dqu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  dqu_pkg::dqu_sts_t sts,
    output dqu_pkg::dqu_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        req_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.op_valid ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load = 1'b1;
                    if (sts.more)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/dqu_dpath.sv
// Ring store, front/count pointers, staged result and output register of the deque unit.
module dqu_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dqu_pkg::dqu_cmd_t                     cmd,
    output dqu_pkg::dqu_sts_t                     sts,
    input  logic [dqu_pkg::OP_W-1:0]              opcode,
    input  logic signed [dqu_pkg::DATA_W-1:0]     data_value,
    input  logic [dqu_pkg::POS_W-1:0]             position,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic [dqu_pkg::STAT_W-1:0]            status,
    output logic signed [dqu_pkg::DATA_W-1:0]     result_value,
    output logic [dqu_pkg::POS_W-1:0]             result_position,
    output logic                                  last
);

    // Latched request
    logic [dqu_pkg::OP_W-1:0]   op_reg;
    logic [dqu_pkg::DATA_W-1:0] data_reg;
    logic [dqu_pkg::POS_W-1:0]  pos_reg;

    // Queue state
    logic [dqu_pkg::ADDR_W-1:0] front_reg;
    logic [dqu_pkg::ADDR_W-1:0] front_next;
    logic [dqu_pkg::CNT_W-1:0]  count_reg;
    logic [dqu_pkg::CNT_W-1:0]  count_next;
    logic [dqu_pkg::POS_W-1:0]  dump_idx_reg;

    // Store
    logic [dqu_pkg::DATA_W-1:0] mem [dqu_pkg::DEPTH];
    logic [dqu_pkg::DATA_W-1:0] rdata_reg;
    logic [dqu_pkg::ADDR_W-1:0] mem_addr;
    logic                       mem_we;

    // Staged result
    logic [dqu_pkg::STAT_W-1:0] stg_status_reg;
    logic [dqu_pkg::POS_W-1:0]  stg_pos_reg;
    logic                       stg_hasval_reg;
    logic                       stg_last_reg;
    logic                       stg_more_reg;
    logic [dqu_pkg::STAT_W-1:0] stg_status_next;
    logic [dqu_pkg::POS_W-1:0]  stg_pos_next;
    logic                       stg_hasval_next;
    logic                       stg_last_next;

    // Output register
    logic                       rsp_valid_reg;
    logic [dqu_pkg::STAT_W-1:0] status_reg;
    logic [dqu_pkg::DATA_W-1:0] value_reg;
    logic [dqu_pkg::POS_W-1:0]  rpos_reg;
    logic                       last_reg;

    logic                       full;
    logic                       empty;
    logic [dqu_pkg::CNT_W-1:0]  count_dec;
    logic [dqu_pkg::ADDR_W-1:0] front_inc;
    logic [dqu_pkg::ADDR_W-1:0] front_dec;
    logic                       read_hit;
    logic                       dump_end;

    assign full      = (count_reg == dqu_pkg::CNT_W'(dqu_pkg::DEPTH));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - dqu_pkg::CNT_W'(1);
    assign front_inc = (front_reg == dqu_pkg::ADDR_W'(dqu_pkg::DEPTH - 1)) ?
                       '0 : front_reg + dqu_pkg::ADDR_W'(1);
    assign front_dec = (front_reg == '0) ?
                       dqu_pkg::ADDR_W'(dqu_pkg::DEPTH - 1) : front_reg - dqu_pkg::ADDR_W'(1);
    assign read_hit  = (dqu_pkg::CMP_W'(pos_reg) < dqu_pkg::CMP_W'(count_reg));
    // Last dump entry: end of the queue or the final reportable position
    assign dump_end  = ((dqu_pkg::CMP_W'(dump_idx_reg) + dqu_pkg::CMP_W'(1))
                        == dqu_pkg::CMP_W'(count_reg))
                       || (dump_idx_reg == dqu_pkg::POS_W'(dqu_pkg::MAX_OUT - 1));

    always_comb
    begin
        mem_addr        = front_reg;
        mem_we          = 1'b0;
        front_next      = front_reg;
        count_next      = count_reg;
        stg_status_next = dqu_pkg::ST_OK;
        stg_pos_next    = '0;
        stg_hasval_next = 1'b0;
        stg_last_next   = 1'b1;
        case (op_reg)
            dqu_pkg::OP_PUSH_BACK:
            begin
                mem_addr = dqu_pkg::ring_slot(front_reg, dqu_pkg::CMP_W'(count_reg));
                if (full)
                begin
                    stg_status_next = dqu_pkg::ST_FULL;
                end
                else
                begin
                    mem_we       = 1'b1;
                    count_next   = count_reg + dqu_pkg::CNT_W'(1);
                    stg_pos_next = count_reg[dqu_pkg::POS_W-1:0];
                end
            end
            dqu_pkg::OP_PUSH_FRONT:
            begin
                mem_addr = front_dec;
                if (full)
                begin
                    stg_status_next = dqu_pkg::ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + dqu_pkg::CNT_W'(1);
                end
            end
            dqu_pkg::OP_POP_BACK:
            begin
                mem_addr = dqu_pkg::ring_slot(front_reg, dqu_pkg::CMP_W'(count_dec));
                if (empty)
                begin
                    stg_status_next = dqu_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next      = count_dec;
                    stg_pos_next    = count_dec[dqu_pkg::POS_W-1:0];
                    stg_hasval_next = 1'b1;
                end
            end
            dqu_pkg::OP_POP_FRONT:
            begin
                mem_addr = front_reg;
                if (empty)
                begin
                    stg_status_next = dqu_pkg::ST_EMPTY;
                end
                else
                begin
                    front_next      = front_inc;
                    count_next      = count_dec;
                    stg_hasval_next = 1'b1;
                end
            end
            dqu_pkg::OP_READ:
            begin
                mem_addr     = dqu_pkg::ring_slot(front_reg, dqu_pkg::CMP_W'(pos_reg));
                stg_pos_next = pos_reg;
                if (read_hit)
                begin
                    stg_hasval_next = 1'b1;
                end
                else
                begin
                    stg_status_next = dqu_pkg::ST_NOT_FOUND;
                end
            end
            dqu_pkg::OP_DUMP:
            begin
                mem_addr = dqu_pkg::ring_slot(front_reg, dqu_pkg::CMP_W'(dump_idx_reg));
                if (empty)
                begin
                    stg_status_next = dqu_pkg::ST_EMPTY;
                end
                else
                begin
                    stg_pos_next    = dump_idx_reg;
                    stg_hasval_next = 1'b1;
                    stg_last_next   = dump_end;
                end
            end
            default:
            begin
                mem_addr = front_reg;
            end
        endcase
    end

    // Store: one access per exec step, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (mem_we)
            begin
                mem[mem_addr] <= data_reg;
            end
            rdata_reg <= mem[mem_addr];
        end
    end

    // Request latch and staged result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            data_reg <= data_value;
            pos_reg  <= position;
        end
        if (cmd.exec)
        begin
            stg_status_reg <= stg_status_next;
            stg_pos_reg    <= stg_pos_next;
            stg_hasval_reg <= stg_hasval_next;
            stg_last_reg   <= stg_last_next;
        end
        if (cmd.load)
        begin
            status_reg <= stg_status_reg;
            value_reg  <= stg_hasval_reg ? rdata_reg : '0;
            rpos_reg   <= stg_pos_reg;
            last_reg   <= stg_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            stg_more_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                front_reg    <= front_next;
                count_reg    <= count_next;
                stg_more_reg <= (op_reg == dqu_pkg::OP_DUMP) && !stg_last_next;
            end
            if (cmd.capture)
            begin
                dump_idx_reg <= '0;
            end
            else if (cmd.advance)
            begin
                dump_idx_reg <= dump_idx_reg + dqu_pkg::POS_W'(1);
            end
            if (cmd.load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.op_valid = op_reg inside {dqu_pkg::OP_PUSH_BACK, dqu_pkg::OP_PUSH_FRONT,
                                         dqu_pkg::OP_POP_BACK, dqu_pkg::OP_POP_FRONT,
                                         dqu_pkg::OP_READ, dqu_pkg::OP_DUMP};
    assign sts.out_free = !rsp_valid_reg || !rsp_stall;
    assign sts.more     = stg_more_reg;

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign result_value    = value_reg;
    assign result_position = rpos_reg;
    assign last            = last_reg;

endmodule

>>> rtl/double_ended_queue_unit.sv
// Top level of the bounded double-ended queue unit.
//
//  Channel   Handshake             Payload
//  --------  --------------------  ----------------------------------------------
//  request   req_valid/req_stall   opcode, data_value, position
//  result    rsp_valid/rsp_stall   status, result_value, result_position, last
//
// One request is in flight at a time. Push, pop and read each go through
// accept, one store access and a load of the output register. A dump does
// a store read and an output load for each reported entry, up to sixteen entries;
// opcodes six and seven are dropped after the access step with no result.
// A stalled result holds the output register; req_stall stays high until the
// last result of a request is loaded. Reset clears front, count and handshakes.
module double_ended_queue_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [dqu_pkg::OP_W-1:0]          opcode,
    input  logic signed [dqu_pkg::DATA_W-1:0] data_value,
    input  logic [dqu_pkg::POS_W-1:0]         position,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [dqu_pkg::STAT_W-1:0]        status,
    output logic signed [dqu_pkg::DATA_W-1:0] result_value,
    output logic [dqu_pkg::POS_W-1:0]         result_position,
    output logic                              last
);

    dqu_pkg::dqu_cmd_t cmd;
    dqu_pkg::dqu_sts_t sts;

    // Sequence each request: accept, access the store, deliver results
    dqu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold the ring store, pointers and the output register
    dqu_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .opcode          (opcode),
        .data_value      (data_value),
        .position        (position),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .result_value    (result_value),
        .result_position (result_position),
        .last            (last)
    );

endmodule
